@@ hdl/best_fit_role_allocator_top_defines.svh @@
// assertion macros for the best-fit allocator
// used by the modules that carry concurrent assertions, no dependencies
`ifndef BEST_FIT_ROLE_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_ROLE_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BFRA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BFRA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/bfra_pkg.sv @@
// shared constants, codes and control structs for the best-fit allocator
// no dependencies
`timescale 1ns / 1ps

package bfra_pkg;

	localparam int DEPTH      = 64;
	localparam int SCORE_BITS = 16;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int KIND_W     = 2;
	localparam int VALUE_W    = 16;
	localparam int STATUS_W   = 2;
	localparam int ENTRY_W    = 7;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_NOFIT = 2'd2
	} status_t;

	typedef struct packed {
		logic latch;
		logic scan_start;
		logic scan_rd;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              cnt_zero;
		logic              scan_last;
		logic              out_busy;
	} dp_stat_t;

endpackage

@@ hdl/bfra_ctrl.sv @@
// controller state machine for the best-fit allocator
// depends on bfra_pkg
`timescale 1ns / 1ps

module bfra_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output bfra_pkg::dp_cmd_t  cmd,
	input  bfra_pkg::dp_stat_t stat
);
	import bfra_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.kind == KIND_QUERY && !stat.cnt_zero) begin
					cmd.scan_start = 1'b1;
					state_nxt      = S_SCAN;
				end else begin
					state_nxt = S_RESP;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_RESP;
			end
			S_RESP: begin
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ hdl/bfra_dpath.sv @@
// datapath: score memory, live bits, scan compare and output register
// depends on bfra_pkg and best_fit_role_allocator_top_defines.svh
`timescale 1ns / 1ps
`include "best_fit_role_allocator_top_defines.svh"

module bfra_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [bfra_pkg::VALUE_W-1:0]        s_tdata,
	input  logic [bfra_pkg::KIND_W-1:0]         s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bfra_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [bfra_pkg::STATUS_W-1:0]       m_tuser,
	input  bfra_pkg::dp_cmd_t                   cmd,
	output bfra_pkg::dp_stat_t                  stat
);
	import bfra_pkg::*;

	logic [SCORE_BITS-1:0] mem [DEPTH];

	logic [KIND_W-1:0]     kind_q;
	logic [SCORE_BITS-1:0] val_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DEPTH-1:0]      live_q;
	logic [IDX_W-1:0]      addr_q;
	logic [SCORE_BITS-1:0] rd_data_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  vld_s1;
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [SCORE_BITS-1:0] best_score_q;
	logic                  m_valid_q;
	logic [STATUS_W-1:0]   m_status_q;
	logic [ENTRY_W-1:0]    m_entry_q;

	logic                  full;
	logic                  hit;
	logic                  do_load;
	logic [CNT_W-1:0]      cnt_m1;
	logic [CNT_W-1:0]      grant_num;
	logic [STATUS_W-1:0]   res_status;
	logic [ENTRY_W-1:0]    res_entry;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign do_load   = cmd.commit && (kind_q == KIND_LOAD) && !full;
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign grant_num = CNT_W'(best_idx_q) + CNT_W'(1);
	assign hit       = vld_s1 && live_q[idx_s1] && (rd_data_s1 >= val_q)
		&& (!found_q || (rd_data_s1 < best_score_q));

	always_comb begin
		res_status = ST_OK;
		res_entry  = '0;
		case (kind_q)
			KIND_CLEAR: begin
				res_status = ST_OK;
			end
			KIND_LOAD: begin
				res_status = full ? ST_FULL : ST_OK;
			end
			KIND_QUERY: begin
				if (found_q) begin
					res_status = ST_OK;
					res_entry  = ENTRY_W'(grant_num);
				end else begin
					res_status = ST_NOFIT;
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	// single port score memory
	always_ff @(posedge clk) begin
		if (do_load) begin
			mem[cnt_q[IDX_W-1:0]] <= val_q;
		end else if (cmd.scan_rd) begin
			rd_data_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= s_tuser;
			val_q  <= s_tdata[SCORE_BITS-1:0];
		end
		if (cmd.scan_rd) begin
			idx_s1 <= addr_q;
		end
		if (hit) begin
			best_idx_q   <= idx_s1;
			best_score_q <= rd_data_s1;
		end
		if (cmd.commit) begin
			m_status_q <= res_status;
			m_entry_q  <= res_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			live_q    <= '0;
			addr_q    <= '0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_rd;
			if (cmd.scan_start) begin
				addr_q <= '0;
			end else if (cmd.scan_rd) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			if (cmd.latch) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				case (kind_q)
					KIND_CLEAR: begin
						live_q <= '0;
						cnt_q  <= '0;
					end
					KIND_LOAD: begin
						if (!full) begin
							live_q[cnt_q[IDX_W-1:0]] <= 1'b1;
							cnt_q                    <= cnt_q + CNT_W'(1);
						end
					end
					KIND_QUERY: begin
						if (found_q) begin
							live_q[best_idx_q] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid       = m_valid_q;
	assign m_tdata        = {{(OUT_DATA_W - ENTRY_W){1'b0}}, m_entry_q};
	assign m_tuser        = m_status_q;
	assign stat.kind      = kind_q;
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.scan_last = (CNT_W'(addr_q) == cnt_m1);
	assign stat.out_busy  = m_valid_q && !m_tready;

	`BFRA_ASSERT_NEXT(a_grant_clears_live, clk, arst_n, cmd.commit && kind_q == KIND_QUERY && found_q, !live_q[best_idx_q])
	`BFRA_ASSERT_IMPL(a_count_bounded, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`BFRA_ASSERT_IMPL(a_fail_has_no_number, clk, arst_n, m_valid_q && m_status_q != ST_OK, m_entry_q == '0)

endmodule

@@ hdl/best_fit_role_allocator_top.sv @@
// best-fit allocator: a scored entry list with append, clear and best-fit grant-and-remove.
// One item is handled at a time; the input is taken again while a result still waits in
// the output register. Clear, load, unused kinds and a query on an empty table go from the
// execute state straight to the response state; a query on a loaded table scans, reading
// the single port score memory once per loaded entry, then drains. A held result stalls
// the next item in its response state. Live flags are flops cleared by reset, so there is
// no clearing pass after reset. Ties in score go to the lowest entry number.
// depends on bfra_pkg, bfra_ctrl and bfra_dpath
`timescale 1ns / 1ps

module best_fit_role_allocator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bfra_pkg::VALUE_W-1:0]    s_tdata,  // value
	input  logic [bfra_pkg::KIND_W-1:0]     s_tuser,  // kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bfra_pkg::OUT_DATA_W-1:0] m_tdata,  // entry_number, zero pad
	output logic [bfra_pkg::STATUS_W-1:0]   m_tuser   // status
);
	import bfra_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bfra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	bfra_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
